### rtl/hlsc_pkg.sv
// ----------------------------------------------------------------------------
// hlsc_pkg
// Shared types and constants for the hashed LRU slot cache directory.
// ----------------------------------------------------------------------------
package hlsc_pkg;

   localparam int SLOT_COUNT_DEF = 1024;
   localparam int SLOT_FIELD_W   = 10;
   localparam int SUM_W          = 64;

   localparam logic [31:0] HASH_NODE_MULT  = 32'd4711;
   localparam logic [31:0] HASH_GROUP_MULT = 32'd5;

   typedef enum logic [1:0] {
      CMD_GET    = 2'd0,
      CMD_LOCK   = 2'd1,
      CMD_UNLOCK = 2'd2,
      CMD_NONE   = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      STAT_HIT       = 2'd0,
      STAT_MISS      = 2'd1,
      STAT_VIC_LOCK  = 2'd2,
      STAT_LOCK_DONE = 2'd3
   } stat_type;

   typedef struct packed {
      logic [31:0] grp_id;
      logic [63:0] msg_number;
      logic [7:0]  node_id;
   } key_type;

   typedef struct packed {
      logic [1:0]              cmd;
      logic [31:0]             grp_id;
      logic [63:0]             msg_number;
      logic [7:0]              node_id;
      logic [SLOT_FIELD_W-1:0] slot;
   } req_type;

   typedef struct packed {
      logic [SLOT_FIELD_W-1:0] slot_out;
      logic [1:0]              status;
      logic                    prior_lock;
   } rsp_type;

   typedef enum logic [2:0] {
      H_IDLE,
      H_LOW,
      H_SUM,
      H_MOD,
      H_RED,
      H_DONE
   } hash_state_type;

   typedef enum logic [4:0] {
      E_CLEAR,
      E_IDLE,
      E_LOCK,
      E_HASH,
      E_HEAD,
      E_WALK,
      E_CMP,
      E_VIC,
      E_VHASH,
      E_UHEAD,
      E_UWALK,
      E_UCMP,
      E_INSERT,
      E_INS2,
      E_MN1,
      E_MN2,
      E_MN3,
      E_MN4,
      E_RESP
   } eng_state_type;

endpackage

### rtl/hlsc_hash.sv
// ----------------------------------------------------------------------------
// hlsc_hash
// Key hash unit: 4711*node + 5*group, plus message number, reduced modulo
// the slot count. When that count is not a power of two the sum is reduced
// 16 bits at a time by reciprocal multiplication, each step in H_MOD then H_RED.
// ----------------------------------------------------------------------------
module hlsc_hash
   import hlsc_pkg::*;
#(
   parameter int SLOT_COUNT = SLOT_COUNT_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  key_type                       key,
   output logic                          done,
   output logic [$clog2(SLOT_COUNT)-1:0] bucket
);

   localparam int          SLOT_W  = $clog2(SLOT_COUNT);
   localparam bit          POW2    = (SLOT_COUNT == (1 << SLOT_W));
   localparam logic [31:0] DIVISOR = 32'(SLOT_COUNT);
   localparam logic [31:0] RECIP   = 32'((64'd1 << 32) / SLOT_COUNT);

   hash_state_type       state_ff, state_in;
   key_type              key_ff, key_in;
   logic [31:0]          low_ff, low_in;
   logic [SUM_W-1:0]     sum_ff, sum_in;
   logic [SLOT_W-1:0]    rem_ff, rem_in;
   logic [31:0]          qe_ff, qe_in;
   logic [1:0]           cnt_ff, cnt_in;
   logic [31:0]          part;
   logic [63:0]          prod;
   logic [31:0]          diff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= H_IDLE;
      end else begin
         state_ff <= state_in;
      end
      key_ff <= key_in;
      low_ff <= low_in;
      sum_ff <= sum_in;
      rem_ff <= rem_in;
      qe_ff  <= qe_in;
      cnt_ff <= cnt_in;
   end

   assign part = {16'(rem_ff), sum_ff[SUM_W-1 -: 16]};
   assign prod = {32'd0, part} * {32'd0, RECIP};
   assign diff = part - 32'(qe_ff * DIVISOR);

   always_comb begin
      state_in = state_ff;
      key_in   = key_ff;
      low_in   = low_ff;
      sum_in   = sum_ff;
      rem_in   = rem_ff;
      qe_in    = qe_ff;
      cnt_in   = cnt_ff;
      unique case (state_ff)
         H_IDLE: begin
            if (start) begin
               key_in   = key;
               state_in = H_LOW;
            end
         end
         H_LOW: begin
            low_in = 32'(HASH_NODE_MULT * {24'd0, key_ff.node_id})
                   + 32'(HASH_GROUP_MULT * key_ff.grp_id);
            state_in = H_SUM;
         end
         H_SUM: begin
            sum_in = {32'd0, low_ff} + key_ff.msg_number;
            rem_in = '0;
            cnt_in = '0;
            state_in = POW2 ? H_DONE : H_MOD;
         end
         H_MOD: begin
            qe_in    = prod[63:32];
            state_in = H_RED;
         end
         H_RED: begin
            if (diff >= DIVISOR) begin
               rem_in = SLOT_W'(diff - DIVISOR);
            end else begin
               rem_in = SLOT_W'(diff);
            end
            sum_in = {sum_ff[SUM_W-17:0], 16'd0};
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == 2'd3) begin
               state_in = H_DONE;
            end else begin
               state_in = H_MOD;
            end
         end
         H_DONE: begin
            state_in = H_IDLE;
         end
         default: begin
            state_in = H_IDLE;
         end
      endcase
   end

   assign done   = (state_ff == H_DONE);
   assign bucket = POW2 ? sum_ff[SLOT_W-1:0] : rem_ff;

endmodule

### rtl/hlsc_engine.sv
// ----------------------------------------------------------------------------
// hlsc_engine
// Directory sequencer: slot tag, flag, chain and recency memories, bucket
// head memory, and the state machine that walks and relinks them.
// ----------------------------------------------------------------------------
module hlsc_engine
   import hlsc_pkg::*;
#(
   parameter int SLOT_COUNT = SLOT_COUNT_DEF
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    res_valid,
   input  logic    res_ready,
   output rsp_type res_data
);

   localparam int SLOT_W = $clog2(SLOT_COUNT);
   localparam int SW     = (SLOT_W > SLOT_FIELD_W) ? SLOT_W : SLOT_FIELD_W;
   localparam logic [SLOT_W:0]   EMPTY_LINK = (SLOT_W+1)'(SLOT_COUNT);
   localparam logic [SLOT_W-1:0] LAST_SLOT  = SLOT_W'(SLOT_COUNT - 1);

   key_type           tag_mem   [SLOT_COUNT];
   logic              valid_mem [SLOT_COUNT];
   logic              lock_mem  [SLOT_COUNT];
   logic [SLOT_W:0]   next_mem  [SLOT_COUNT];
   logic [SLOT_W-1:0] prev_mem  [SLOT_COUNT];
   logic [SLOT_W-1:0] anext_mem [SLOT_COUNT];
   logic [SLOT_W:0]   bkt_mem   [SLOT_COUNT];

   key_type           tag_rd_ff;
   logic              valid_rd_ff, lock_rd_ff;
   logic [SLOT_W:0]   next_rd_ff, bkt_rd_ff;
   logic [SLOT_W-1:0] prev_rd_ff, anext_rd_ff;

   logic [SLOT_W-1:0] ra_slot, ra_bkt;
   logic              we_tag, we_valid, we_lock, we_next, we_prev, we_anext, we_bkt;
   logic [SLOT_W-1:0] wa_tag, wa_valid, wa_lock, wa_next, wa_prev, wa_anext, wa_bkt;
   key_type           wd_tag;
   logic              wd_valid, wd_lock;
   logic [SLOT_W:0]   wd_next, wd_bkt;
   logic [SLOT_W-1:0] wd_prev, wd_anext;

   eng_state_type         state_ff, state_in;
   logic [SLOT_W-1:0]     clr_ff, clr_in;
   logic [1:0]            cmd_ff, cmd_in;
   key_type               key_ff, key_in;
   logic [SLOT_FIELD_W-1:0] slot_ff, slot_in;
   logic                  slot_ok_ff, slot_ok_in;
   logic [SLOT_W-1:0]     bkt_ff, bkt_in;
   logic [SLOT_W-1:0]     obkt_ff, obkt_in;
   logic [SLOT_W:0]       cur_ff, cur_in;
   logic [SLOT_W-1:0]     mn_ff, mn_in;
   logic [SLOT_W:0]       vnext_ff, vnext_in;
   logic [SLOT_W-1:0]     oldest_ff, oldest_in;
   logic [SLOT_W-1:0]     newest_ff, newest_in;
   logic [SLOT_FIELD_W-1:0] res_slot_ff, res_slot_in;
   stat_type              res_status_ff, res_status_in;
   logic                  res_prior_ff, res_prior_in;

   logic                  hash_start, hash_done;
   key_type               hash_key;
   logic [SLOT_W-1:0]     hash_bucket;
   logic [SW-1:0]         req_slot_ext, slot_ext;

   hlsc_hash #(
      .SLOT_COUNT(SLOT_COUNT)
   ) u_hash (
      .clock (clock),
      .reset (reset),
      .start (hash_start),
      .key   (hash_key),
      .done  (hash_done),
      .bucket(hash_bucket)
   );

   always_ff @(posedge clock) begin
      if (we_tag) begin
         tag_mem[wa_tag] <= wd_tag;
      end
      if (we_valid) begin
         valid_mem[wa_valid] <= wd_valid;
      end
      if (we_lock) begin
         lock_mem[wa_lock] <= wd_lock;
      end
      if (we_next) begin
         next_mem[wa_next] <= wd_next;
      end
      if (we_prev) begin
         prev_mem[wa_prev] <= wd_prev;
      end
      if (we_anext) begin
         anext_mem[wa_anext] <= wd_anext;
      end
      if (we_bkt) begin
         bkt_mem[wa_bkt] <= wd_bkt;
      end
      tag_rd_ff   <= tag_mem[ra_slot];
      valid_rd_ff <= valid_mem[ra_slot];
      lock_rd_ff  <= lock_mem[ra_slot];
      next_rd_ff  <= next_mem[ra_slot];
      prev_rd_ff  <= prev_mem[ra_slot];
      anext_rd_ff <= anext_mem[ra_slot];
      bkt_rd_ff   <= bkt_mem[ra_bkt];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= E_CLEAR;
         clr_ff    <= '0;
         oldest_ff <= '0;
         newest_ff <= LAST_SLOT;
      end else begin
         state_ff  <= state_in;
         clr_ff    <= clr_in;
         oldest_ff <= oldest_in;
         newest_ff <= newest_in;
      end
      cmd_ff        <= cmd_in;
      key_ff        <= key_in;
      slot_ff       <= slot_in;
      slot_ok_ff    <= slot_ok_in;
      bkt_ff        <= bkt_in;
      obkt_ff       <= obkt_in;
      cur_ff        <= cur_in;
      mn_ff         <= mn_in;
      vnext_ff      <= vnext_in;
      res_slot_ff   <= res_slot_in;
      res_status_ff <= res_status_in;
      res_prior_ff  <= res_prior_in;
   end

   assign req_slot_ext = SW'(req_data.slot);
   assign slot_ext     = SW'(slot_ff);

   always_comb begin
      state_in      = state_ff;
      clr_in        = clr_ff;
      cmd_in        = cmd_ff;
      key_in        = key_ff;
      slot_in       = slot_ff;
      slot_ok_in    = slot_ok_ff;
      bkt_in        = bkt_ff;
      obkt_in       = obkt_ff;
      cur_in        = cur_ff;
      mn_in         = mn_ff;
      vnext_in      = vnext_ff;
      oldest_in     = oldest_ff;
      newest_in     = newest_ff;
      res_slot_in   = res_slot_ff;
      res_status_in = res_status_ff;
      res_prior_in  = res_prior_ff;
      req_ready     = 1'b0;
      res_valid     = 1'b0;
      hash_start    = 1'b0;
      hash_key      = key_ff;
      ra_slot       = cur_ff[SLOT_W-1:0];
      ra_bkt        = bkt_ff;
      we_tag   = 1'b0;  wa_tag   = mn_ff;  wd_tag   = key_ff;
      we_valid = 1'b0;  wa_valid = mn_ff;  wd_valid = 1'b1;
      we_lock  = 1'b0;  wa_lock  = mn_ff;  wd_lock  = 1'b0;
      we_next  = 1'b0;  wa_next  = mn_ff;  wd_next  = EMPTY_LINK;
      we_prev  = 1'b0;  wa_prev  = mn_ff;  wd_prev  = newest_ff;
      we_anext = 1'b0;  wa_anext = mn_ff;  wd_anext = '0;
      we_bkt   = 1'b0;  wa_bkt   = bkt_ff; wd_bkt   = EMPTY_LINK;
      unique case (state_ff)
         E_CLEAR: begin
            we_valid = 1'b1;  wa_valid = clr_ff;  wd_valid = 1'b0;
            we_lock  = 1'b1;  wa_lock  = clr_ff;  wd_lock  = 1'b0;
            we_next  = 1'b1;  wa_next  = clr_ff;  wd_next  = EMPTY_LINK;
            we_bkt   = 1'b1;  wa_bkt   = clr_ff;  wd_bkt   = EMPTY_LINK;
            we_prev  = 1'b1;  wa_prev  = clr_ff;
            wd_prev  = (clr_ff == '0) ? '0 : clr_ff - 1'b1;
            we_anext = 1'b1;  wa_anext = clr_ff;
            wd_anext = (clr_ff == LAST_SLOT) ? '0 : clr_ff + 1'b1;
            clr_in   = clr_ff + 1'b1;
            if (clr_ff == LAST_SLOT) begin
               state_in = E_IDLE;
            end
         end
         E_IDLE: begin
            req_ready = 1'b1;
            ra_slot   = req_slot_ext[SLOT_W-1:0];
            hash_key  = '{grp_id: req_data.grp_id,
                          msg_number: req_data.msg_number,
                          node_id: req_data.node_id};
            if (req_valid) begin
               cmd_in     = req_data.cmd;
               key_in     = hash_key;
               slot_in    = req_data.slot;
               slot_ok_in = ({1'b0, req_slot_ext} < (SW+1)'(SLOT_COUNT));
               if (req_data.cmd == CMD_GET) begin
                  hash_start = 1'b1;
                  state_in   = E_HASH;
               end else begin
                  state_in = E_LOCK;
               end
            end
         end
         E_LOCK: begin
            wa_lock       = slot_ext[SLOT_W-1:0];
            res_slot_in   = slot_ff;
            res_status_in = STAT_LOCK_DONE;
            res_prior_in  = slot_ok_ff & lock_rd_ff;
            if (slot_ok_ff && (cmd_ff == CMD_LOCK || cmd_ff == CMD_UNLOCK)) begin
               we_lock = 1'b1;
               wd_lock = (cmd_ff == CMD_LOCK);
            end
            state_in = E_RESP;
         end
         E_HASH: begin
            if (hash_done) begin
               bkt_in   = hash_bucket;
               ra_bkt   = hash_bucket;
               state_in = E_HEAD;
            end
         end
         E_HEAD: begin
            cur_in   = bkt_rd_ff;
            state_in = E_WALK;
         end
         E_WALK: begin
            if (cur_ff >= EMPTY_LINK) begin
               ra_slot  = oldest_ff;
               state_in = E_VIC;
            end else begin
               state_in = E_CMP;
            end
         end
         E_CMP: begin
            if (valid_rd_ff && tag_rd_ff == key_ff) begin
               res_slot_in   = SLOT_FIELD_W'(cur_ff[SLOT_W-1:0]);
               res_status_in = STAT_HIT;
               res_prior_in  = lock_rd_ff;
               mn_in         = cur_ff[SLOT_W-1:0];
               state_in      = E_MN1;
            end else begin
               cur_in   = next_rd_ff;
               state_in = E_WALK;
            end
         end
         E_VIC: begin
            res_slot_in = SLOT_FIELD_W'(oldest_ff);
            mn_in       = oldest_ff;
            if (lock_rd_ff) begin
               res_status_in = STAT_VIC_LOCK;
               res_prior_in  = 1'b1;
               state_in      = E_RESP;
            end else begin
               res_status_in = STAT_MISS;
               res_prior_in  = 1'b0;
               vnext_in      = next_rd_ff;
               if (valid_rd_ff) begin
                  hash_start = 1'b1;
                  hash_key   = tag_rd_ff;
                  state_in   = E_VHASH;
               end else begin
                  state_in = E_INSERT;
               end
            end
         end
         E_VHASH: begin
            if (hash_done) begin
               obkt_in  = hash_bucket;
               ra_bkt   = hash_bucket;
               state_in = E_UHEAD;
            end
         end
         E_UHEAD: begin
            if (bkt_rd_ff == {1'b0, mn_ff}) begin
               we_bkt   = 1'b1;
               wa_bkt   = obkt_ff;
               wd_bkt   = vnext_ff;
               state_in = E_INSERT;
            end else begin
               cur_in   = bkt_rd_ff;
               state_in = E_UWALK;
            end
         end
         E_UWALK: begin
            state_in = (cur_ff >= EMPTY_LINK) ? E_INSERT : E_UCMP;
         end
         E_UCMP: begin
            if (next_rd_ff == {1'b0, mn_ff}) begin
               we_next  = 1'b1;
               wa_next  = cur_ff[SLOT_W-1:0];
               wd_next  = vnext_ff;
               state_in = E_INSERT;
            end else begin
               cur_in   = next_rd_ff;
               state_in = E_UWALK;
            end
         end
         E_INSERT: begin
            we_tag   = 1'b1;
            we_valid = 1'b1;
            we_lock  = 1'b1;
            state_in = E_INS2;
         end
         E_INS2: begin
            we_next  = 1'b1;
            wd_next  = bkt_rd_ff;
            we_bkt   = 1'b1;
            wd_bkt   = {1'b0, mn_ff};
            state_in = E_MN1;
         end
         E_MN1: begin
            ra_slot  = mn_ff;
            state_in = (mn_ff == newest_ff) ? E_RESP : E_MN2;
         end
         E_MN2: begin
            if (mn_ff == oldest_ff) begin
               oldest_in = anext_rd_ff;
            end else begin
               we_anext = 1'b1;
               wa_anext = prev_rd_ff;
               wd_anext = anext_rd_ff;
            end
            we_prev  = 1'b1;
            wa_prev  = anext_rd_ff;
            wd_prev  = prev_rd_ff;
            state_in = E_MN3;
         end
         E_MN3: begin
            we_prev  = 1'b1;
            we_anext = 1'b1;
            wa_anext = newest_ff;
            wd_anext = mn_ff;
            state_in = E_MN4;
         end
         E_MN4: begin
            we_anext  = 1'b1;
            newest_in = mn_ff;
            state_in  = E_RESP;
         end
         E_RESP: begin
            res_valid = 1'b1;
            if (res_ready) begin
               state_in = E_IDLE;
            end
         end
         default: begin
            state_in = E_IDLE;
         end
      endcase
   end

   assign res_data.slot_out   = res_slot_ff;
   assign res_data.status     = res_status_ff;
   assign res_data.prior_lock = res_prior_ff;

endmodule

### rtl/hashed_lru_slot_cache.sv
// ----------------------------------------------------------------------------
// hashed_lru_slot_cache
// Hash-indexed directory of slots keyed by group, message number and node,
// with least-recently-used replacement and per-slot lock bits.
//
// The req_ channel carries one command per transfer: get a slot for a key,
// lock a slot or unlock a slot. The rsp_ channel returns one result per
// command: the slot, a status code and the slot's lock bit before the command.
// Commands are processed one at a time by a sequencer around memories with
// one write port and one registered read port each. Lock and unlock pass
// through E_LOCK to E_RESP. A get first hashes the key: a slot count that
// is a power of two skips the remainder unit, otherwise that unit reduces
// the sum 16 bits per step. It then walks the bucket chain entry by entry;
// a refill of a used slot adds a second hash and a walk of its old chain.
// After reset a clearing pass over all SLOT_COUNT slots initializes the flag,
// chain, recency and bucket head memories; req_ready stays low during it.
// A result waits in an output register while rsp_ready is low, and the next
// request can be taken meanwhile.
// ----------------------------------------------------------------------------
module hashed_lru_slot_cache
   import hlsc_pkg::*;
#(
   parameter int SLOT_COUNT = SLOT_COUNT_DEF
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   logic    res_valid, res_ready;
   rsp_type res_data;
   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_data_ff, rsp_data_in;

   hlsc_engine #(
      .SLOT_COUNT(SLOT_COUNT)
   ) u_engine (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data (req_data),
      .res_valid(res_valid),
      .res_ready(res_ready),
      .res_data (res_data)
   );

   assign res_ready = !rsp_valid_ff || rsp_ready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;
      if (res_valid && res_ready) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = res_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

### test/hlsc_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// hlsc_checker
// Watches the request and response channels of the slot cache directory,
// keeps its own model of keys, lock bits, recency order and buckets, and
// compares every response with the oldest predicted one.
// ----------------------------------------------------------------------------
module hlsc_checker
   import hlsc_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   input  logic    req_ready,
   input  req_type req_data,
   input  logic    rsp_valid,
   input  logic    rsp_ready,
   input  rsp_type rsp_data,
   output int      error_count,
   output int      pending_count
);

   localparam int NSLOT = SLOT_COUNT_DEF;

   logic [31:0] key_group [NSLOT];
   logic [63:0] key_msgno [NSLOT];
   logic [7:0]  key_node  [NSLOT];
   bit          in_use    [NSLOT];
   bit          locked    [NSLOT];
   int          older     [NSLOT];
   int          newer     [NSLOT];
   int          lru_slot;
   int          mru_slot;
   int          bucket_members [NSLOT][$];
   rsp_type     pending_rsp [$];

   function automatic int bucket_of(logic [31:0] g, logic [63:0] m, logic [7:0] n);
      logic [31:0] low;
      logic [63:0] sum;
      low = 32'd4711 * {24'd0, n} + 32'd5 * g;
      sum = {32'd0, low} + m;
      return int'(sum % NSLOT);
   endfunction

   function automatic void touch(int s);
      int p;
      int n;
      if (s == mru_slot) return;
      p = older[s];
      n = newer[s];
      if (s == lru_slot) lru_slot = n;
      else newer[p] = n;
      older[n] = p;
      older[s] = mru_slot;
      newer[mru_slot] = s;
      newer[s] = 0;
      mru_slot = s;
   endfunction

   function automatic rsp_type predict_lookup(req_type r);
      rsp_type res;
      int b;
      int hit;
      int v;
      int ob;
      res.slot_out = r.slot;
      res.status = STAT_LOCK_DONE;
      res.prior_lock = 1'b0;
      if (r.cmd == CMD_GET) begin
         b = bucket_of(r.grp_id, r.msg_number, r.node_id);
         hit = -1;
         foreach (bucket_members[b][i]) begin
            if (key_group[bucket_members[b][i]] == r.grp_id &&
                key_msgno[bucket_members[b][i]] == r.msg_number &&
                key_node[bucket_members[b][i]] == r.node_id) hit = bucket_members[b][i];
         end
         if (hit >= 0) begin
            res.slot_out = 10'(hit);
            res.status = STAT_HIT;
            res.prior_lock = locked[hit];
            touch(hit);
         end else begin
            v = lru_slot;
            res.slot_out = 10'(v);
            if (locked[v]) begin
               res.status = STAT_VIC_LOCK;
               res.prior_lock = 1'b1;
            end else begin
               res.status = STAT_MISS;
               if (in_use[v]) begin
                  ob = bucket_of(key_group[v], key_msgno[v], key_node[v]);
                  foreach (bucket_members[ob][i]) begin
                     if (bucket_members[ob][i] == v) begin
                        bucket_members[ob].delete(i);
                        break;
                     end
                  end
               end
               key_group[v] = r.grp_id;
               key_msgno[v] = r.msg_number;
               key_node[v] = r.node_id;
               in_use[v] = 1'b1;
               bucket_members[b].push_back(v);
               touch(v);
            end
         end
      end else begin
         res.prior_lock = locked[r.slot];
         if (r.cmd == CMD_LOCK) locked[r.slot] = 1'b1;
         else if (r.cmd == CMD_UNLOCK) locked[r.slot] = 1'b0;
      end
      return res;
   endfunction

   initial begin
      for (int i = 0; i < NSLOT; i++) begin
         in_use[i] = 1'b0;
         locked[i] = 1'b0;
         older[i] = (i == 0) ? 0 : i - 1;
         newer[i] = (i + 1 < NSLOT) ? i + 1 : 0;
      end
      lru_slot = 0;
      mru_slot = NSLOT - 1;
      error_count = 0;
      pending_count = 0;
   end

   always @(posedge clock) begin
      rsp_type want;
      if (!reset) begin
         if (req_valid && req_ready) pending_rsp.push_back(predict_lookup(req_data));
         if (rsp_valid && rsp_ready) begin
            if (pending_rsp.size() == 0) begin
               $error("unexpected response transfer: %p", rsp_data);
               error_count++;
            end else begin
               want = pending_rsp.pop_front();
               if (rsp_data.slot_out !== want.slot_out) begin
                  $error("slot_out expected %0d actual %0d", want.slot_out, rsp_data.slot_out);
                  error_count++;
               end
               if (rsp_data.status !== want.status) begin
                  $error("status expected %0d actual %0d", want.status, rsp_data.status);
                  error_count++;
               end
               if (rsp_data.prior_lock !== want.prior_lock) begin
                  $error("prior_lock expected %0d actual %0d", want.prior_lock,
                         rsp_data.prior_lock);
                  error_count++;
               end
            end
         end
         pending_count <= pending_rsp.size();
      end
   end

endmodule

### test/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Drives directed and random get, lock and unlock commands into the slot
// cache directory with random idling on both channels, and reports the
// verdict from the checker's failure count.
// ----------------------------------------------------------------------------
module testbench;
   import hlsc_pkg::*;

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_ready;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_ready;
   rsp_type rsp_data;
   int      error_count;
   int      pending_count;
   int      cycle_count;
   int      sent_count;
   bit      hold_rsp;
   bit      calm_rsp;
   bit      calm_req;

   logic [31:0] pool_group [16];
   logic [63:0] pool_msgno [16];
   logic [7:0]  pool_node  [16];

   hashed_lru_slot_cache i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   hlsc_checker i_checker (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_data      (req_data),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_data      (rsp_data),
      .error_count   (error_count),
      .pending_count (pending_count)
   );

   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > 400000) begin
         $display("end of test: mismatches");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (reset) rsp_ready <= 1'b0;
      else if (hold_rsp) rsp_ready <= 1'b0;
      else rsp_ready <= calm_rsp || ($urandom_range(99) >= 26);
   end

   task automatic send_request(req_type r);
      while (!calm_req && $urandom_range(99) < 26) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= r;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      sent_count++;
   endtask

   function automatic req_type make_request(logic [1:0] c, logic [31:0] g, logic [63:0] m,
                                            logic [7:0] n, logic [9:0] s);
      req_type r;
      r.cmd = c;
      r.grp_id = g;
      r.msg_number = m;
      r.node_id = n;
      r.slot = s;
      return r;
   endfunction

   function automatic req_type pick_random();
      int k;
      int sel;
      logic [1:0] c;
      sel = $urandom_range(99);
      k = $urandom_range(15);
      if (sel < 60) c = CMD_GET;
      else if (sel < 75) c = CMD_LOCK;
      else if (sel < 95) c = CMD_UNLOCK;
      else c = CMD_NONE;
      if ($urandom_range(9) < 7)
         return make_request(c, pool_group[k], pool_msgno[k], pool_node[k],
                             ($urandom_range(3) == 0) ? 10'($urandom) : 10'(k));
      return make_request(c, $urandom, {$urandom, $urandom}, 8'($urandom), 10'($urandom));
   endfunction

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      cycle_count = 0;
      sent_count = 0;
      hold_rsp = 1'b0;
      calm_rsp = 1'b0;
      calm_req = 1'b0;
      for (int i = 0; i < 16; i++) begin
         pool_group[i] = $urandom;
         pool_msgno[i] = {$urandom, $urandom};
         pool_node[i] = 8'($urandom);
      end
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_request(make_request(CMD_GET, '0, '0, '0, '0));
      send_request(make_request(CMD_GET, '1, '1, '1, '1));
      send_request(make_request(CMD_GET, '0, '0, '0, '0));
      send_request(make_request(CMD_GET, 32'd1, 64'd1019, 8'd0, '0));
      send_request(make_request(CMD_GET, 32'd0, 64'd1024, 8'd0, '0));
      send_request(make_request(CMD_LOCK, '0, '0, '0, 10'd3));
      send_request(make_request(CMD_LOCK, '0, '0, '0, 10'd3));
      send_request(make_request(CMD_UNLOCK, '0, '0, '0, 10'd3));
      send_request(make_request(CMD_LOCK, '1, '1, '1, 10'd1023));
      send_request(make_request(CMD_UNLOCK, '0, '0, '0, 10'd1023));
      send_request(make_request(CMD_NONE, '1, '1, '1, 10'd3));
      send_request(make_request(CMD_LOCK, '0, '0, '0, 10'd5));
      send_request(make_request(CMD_NONE, '0, '0, '0, 10'd5));
      send_request(make_request(CMD_LOCK, '0, '0, '0, 10'd4));
      send_request(make_request(CMD_GET, 32'h1234, 64'h55, 8'h7, '0));
      send_request(make_request(CMD_UNLOCK, '0, '0, '0, 10'd4));
      send_request(make_request(CMD_GET, 32'h1234, 64'h55, 8'h7, '0));
      send_request(make_request(CMD_GET, 32'h1234, 64'h55, 8'h7, '0));

      hold_rsp = 1'b1;
      fork
         begin
            repeat (300) @(posedge clock);
            hold_rsp = 1'b0;
         end
         for (int i = 0; i < 12; i++) send_request(pick_random());
      join
      req_valid <= 1'b0;

      repeat (2) @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      calm_req = 1'b1;
      calm_rsp = 1'b1;
      for (int i = 0; i < 100; i++) send_request(pick_random());
      calm_req = 1'b0;
      calm_rsp = 1'b0;
      for (int i = 0; i < 520; i++) send_request(pick_random());
      req_valid <= 1'b0;

      while (pending_count != 0 || cycle_count < 0) @(posedge clock);
      repeat (2) @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (300) @(posedge clock);
      if (error_count == 0) $display("end of test: clean");
      else $display("end of test: mismatches");
      $finish;
   end

endmodule
